// File: rtl/core/ptcd_pkg.sv
package ptcd_pkg;

  // request codes on the input channel
  typedef enum logic {
    REQ_START = 1'b0,
    REQ_EDGE  = 1'b1
  } req_e;

  // result codes on the output channel
  typedef enum logic {
    KIND_READING = 1'b0,
    KIND_DONE    = 1'b1
  } kind_e;

  // configuration register indexes
  localparam logic [7:0] CFG_SENSOR_COUNT = 8'd0;
  localparam logic [7:0] CFG_BOARD_NUMBER = 8'd1;

  // reset values of the configuration registers
  localparam logic [7:0] SENSOR_COUNT_RST = 8'd1;
  localparam logic [7:0] BOARD_NUMBER_RST = 8'd0;

  // conversion constants, Q8.8
  localparam int TEMP_OFFSET = 421 * 256;
  localparam int SLOPE_GAIN  = 751 * 256;
  localparam int SLOPE_BITS  = 18;
  // quotient below this saturates high, above the other saturates low
  localparam int Q_SAT_HIGH  = TEMP_OFFSET - 32767;
  localparam int Q_SAT_LOW   = TEMP_OFFSET + 32768;
  localparam int DIFF_BITS   = SLOPE_BITS + 1;
  localparam logic signed [15:0] TEMP_MAX = 16'sh7fff;
  localparam logic signed [15:0] TEMP_MIN = 16'sh8000;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // everything of a job but the two pulse widths
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  board;
    logic [7:0]  sensor;
    logic [31:0] time_us;
  } tag_t;

endpackage

// File: rtl/core/ptcd_if.sv
interface ptcd_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] event_time_us;

  modport source (output valid, req_type, event_time_us, input ready);
  modport sink (input valid, req_type, event_time_us, output ready);
endinterface

interface ptcd_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [7:0]         board_id;
  logic [7:0]         sensor_num;
  logic signed [15:0] temperature_q88;
  logic [31:0]        reading_time_us;

  modport source (output valid, result_kind, board_id, sensor_num, temperature_q88,
                  reading_time_us, input ready);
  modport sink (input valid, result_kind, board_id, sensor_num, temperature_q88,
                reading_time_us, output ready);
endinterface

interface ptcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/ptcd_front.sv
module ptcd_front import ptcd_pkg::*; #(
  parameter int TIMER_BITS = 32,
  parameter int WIDTH_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ptcd_in_if.sink               req_i,
  ptcd_cfg_if.sink              cfg_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output tag_t                  tag_o,
  output logic [WIDTH_BITS-1:0] high_o,
  output logic [WIDTH_BITS-1:0] low_o
);

  localparam int TB = (TIMER_BITS > 32) ? 32 : TIMER_BITS;
  localparam int XW = (TB > WIDTH_BITS) ? TB : WIDTH_BITS;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [TB-1:0]         prev_q, prev_d;
  logic [WIDTH_BITS-1:0] high_q, high_d;
  logic [7:0]            idx_q, idx_d;
  logic [7:0]            count_q, board_q;

  logic                  acc;
  logic [TB-1:0]         now;
  logic [TB-1:0]         diff;
  logic [XW-1:0]         diff_x;
  logic [WIDTH_BITS-1:0] width_raw, width;
  logic [7:0]            idx_inc;

  assign req_i.ready = !q_full_i;
  assign cfg_i.ready = 1'b1;
  assign acc         = req_i.valid && req_i.ready;

  // pulse width since the previous edge, zero counts as one
  assign now       = req_i.event_time_us[TB-1:0];
  assign diff      = TB'(now - prev_q);
  assign diff_x    = XW'(diff);
  assign width_raw = diff_x[WIDTH_BITS-1:0];
  assign width     = (width_raw == '0) ? WIDTH_BITS'(1) : width_raw;
  assign idx_inc   = idx_q + 8'd1;

  assign high_o = high_q;
  assign low_o  = width;

  // edge sequencing and job issue
  always_comb begin
    phase_d       = phase_q;
    prev_d        = prev_q;
    high_d        = high_q;
    idx_d         = idx_q;
    push_o        = 1'b0;
    tag_o.kind    = KIND_READING;
    tag_o.board   = board_q;
    tag_o.sensor  = idx_q;
    tag_o.time_us = 32'(now);
    if (acc) begin
      if (req_i.req_type == REQ_START) begin
        phase_d = PH_HIGH;
        idx_d   = 8'd0;
        prev_d  = now;
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
          end
          PH_HIGH: begin
            prev_d  = now;
            high_d  = width;
            phase_d = PH_LOW;
          end
          PH_LOW: begin
            prev_d = now;
            push_o = 1'b1;
            if (idx_inc >= count_q) begin
              phase_d = PH_DONE;
              idx_d   = 8'd0;
            end else begin
              phase_d = PH_HIGH;
              idx_d   = idx_inc;
            end
          end
          PH_DONE: begin
            prev_d       = now;
            push_o       = 1'b1;
            tag_o.kind   = KIND_DONE;
            tag_o.sensor = 8'd0;
            phase_d      = PH_IDLE;
          end
        endcase
      end
    end
  end

  // state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      prev_q  <= '0;
      high_q  <= '0;
      idx_q   <= '0;
      count_q <= SENSOR_COUNT_RST;
      board_q <= BOARD_NUMBER_RST;
    end else begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      high_q  <= high_d;
      idx_q   <= idx_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          CFG_SENSOR_COUNT: count_q <= cfg_i.data;
          CFG_BOARD_NUMBER: board_q <= cfg_i.data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/core/ptcd_queue.sv
module ptcd_queue import ptcd_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o,
  output logic              full_o
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     count_q;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CW'(QUEUE_DEPTH));
  assign data_o  = mem_q[rd_ptr_q];

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// File: rtl/core/ptcd_back.sv
module ptcd_back import ptcd_pkg::*; #(
  parameter int WIDTH_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  tag_t                  tag_i,
  input  logic [WIDTH_BITS-1:0] high_i,
  input  logic [WIDTH_BITS-1:0] low_i,
  output logic                  pop_o,
  ptcd_out_if.source            rsp_o
);

  localparam int DW = WIDTH_BITS + SLOPE_BITS;
  localparam int CW = $clog2(DW + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DIV  = 2'd1,
    S_HOLD = 2'd2
  } state_e;

  state_e                state_q;
  tag_t                  tag_q;
  logic [DW-1:0]         quo_q, quo_d;
  logic [WIDTH_BITS-1:0] rem_q, rem_d;
  logic [WIDTH_BITS-1:0] lo_q;
  logic [CW-1:0]         cnt_q;

  logic [DW-1:0]         dividend;
  logic [WIDTH_BITS:0]   rem_sh;
  logic                  q_bit;
  logic [DIFF_BITS-1:0]  diff;
  logic signed [15:0]    temp;

  logic                  out_valid_q;
  logic                  out_kind_q;
  logic [7:0]            out_board_q, out_sensor_q;
  logic signed [15:0]    out_temp_q;
  logic [31:0]           out_time_q;

  assign pop_o = (state_q == S_IDLE) && q_valid_i;

  // scaled high width, constant multiply
  assign dividend = DW'(high_i) * DW'(SLOPE_GAIN);

  // one restoring division step
  always_comb begin
    rem_sh = {rem_q, quo_q[DW-1]};
    q_bit  = (rem_sh >= {1'b0, lo_q});
    rem_d  = q_bit ? WIDTH_BITS'(rem_sh - {1'b0, lo_q}) : rem_sh[WIDTH_BITS-1:0];
    quo_d  = {quo_q[DW-2:0], q_bit};
  end

  // offset minus quotient, saturated to 16 bits; zero for a done word
  always_comb begin
    diff = DIFF_BITS'(TEMP_OFFSET) - DIFF_BITS'(quo_q);
    if (tag_q.kind == KIND_DONE) begin
      temp = '0;
    end else if (quo_q > DW'(Q_SAT_LOW)) begin
      temp = TEMP_MIN;
    end else if (quo_q < DW'(Q_SAT_HIGH)) begin
      temp = TEMP_MAX;
    end else begin
      temp = diff[15:0];
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.result_kind     = out_kind_q;
  assign rsp_o.board_id        = out_board_q;
  assign rsp_o.sensor_num      = out_sensor_q;
  assign rsp_o.temperature_q88 = out_temp_q;
  assign rsp_o.reading_time_us = out_time_q;

  // sequencer, divider and output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tag_q        <= '0;
      quo_q        <= '0;
      rem_q        <= '0;
      lo_q         <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= 1'b0;
      out_board_q  <= '0;
      out_sensor_q <= '0;
      out_temp_q   <= '0;
      out_time_q   <= '0;
    end else begin
      // word taken; in the hold state it is refilled below instead
      if (out_valid_q && rsp_o.ready && state_q != S_HOLD) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            tag_q <= tag_i;
            quo_q <= dividend;
            rem_q <= '0;
            lo_q  <= low_i;
            cnt_q <= CW'(DW);
            state_q <= (tag_i.kind == KIND_DONE) ? S_HOLD : S_DIV;
          end
        end
        S_DIV: begin
          quo_q <= quo_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_q <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_kind_q   <= tag_q.kind;
            out_board_q  <= tag_q.board;
            out_sensor_q <= tag_q.sensor;
            out_temp_q   <= temp;
            out_time_q   <= tag_q.time_us;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/pwm_temperature_chain_decoder_unit.sv
// Decoder for a daisy chain of PWM temperature sensors. A start word arms the
// chain and stamps the time; each edge word after it gives the pulse width since
// the previous edge (high, then low). Every low pulse yields one Q8.8 reading,
// 421*256 - 751*256*high/low saturated to 16 bits, and after sensor_count
// readings the next edge yields a done word. The front end takes one input word
// per cycle while its two-entry job queue has room; the back end takes one job at
// a time and finishes it before it takes the next, each reading through its
// one-bit-per-cycle restoring divider, a done word without division. A finished
// word waits in the output register while the next job is worked on.
module pwm_temperature_chain_decoder_unit import ptcd_pkg::*; #(
  parameter int TIMER_BITS = 32,
  parameter int WIDTH_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptcd_in_if.sink    req_i,
  ptcd_cfg_if.sink   cfg_i,
  ptcd_out_if.source rsp_o
);

  localparam int TAG_W = $bits(tag_t);
  localparam int JOB_W = TAG_W + 2 * WIDTH_BITS;

  logic                  q_push, q_full, q_pop, q_valid;
  tag_t                  push_tag, pop_tag;
  logic [WIDTH_BITS-1:0] push_high, push_low, pop_high, pop_low;
  logic [JOB_W-1:0]      q_wdata, q_rdata;

  // front end: edge sequencing and configuration
  ptcd_front #(
    .TIMER_BITS (TIMER_BITS),
    .WIDTH_BITS (WIDTH_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .tag_o    (push_tag),
    .high_o   (push_high),
    .low_o    (push_low)
  );

  assign q_wdata = {push_tag, push_high, push_low};

  // job queue
  ptcd_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .full_o  (q_full)
  );

  assign {pop_tag, pop_high, pop_low} = q_rdata;

  // back end: division, saturation, output register
  ptcd_back #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .tag_i     (pop_tag),
    .high_i    (pop_high),
    .low_i     (pop_low),
    .pop_o     (q_pop),
    .rsp_o     (rsp_o)
  );

  // no job is written into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("job pushed into full queue");

  // the back end only takes a job that is there
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("job popped from empty queue");

  // a done word carries neither a sensor number nor a temperature
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.result_kind == KIND_DONE) |->
      (rsp_o.sensor_num == 8'd0 && rsp_o.temperature_q88 == 16'sd0))
    else $error("done word with reading payload");

endmodule
